@@ src/line_to_line_distance_3d_top_macros.svh @@
// Assertion macros for the line-to-line distance block.
`ifndef LINE_TO_LINE_DISTANCE_3D_TOP_MACROS_SVH
`define LINE_TO_LINE_DISTANCE_3D_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define L2L_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("l2l check failed");
`define L2L_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("l2l check failed");
`else
`define L2L_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define L2L_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ src/l2l_pkg.sv @@
// Shared constants, types and width helpers for the line-to-line distance block.
`default_nettype none
package l2l_pkg;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int NUM_FIELDS      = 12;
    localparam int DIST_W          = 17;
    localparam int FRAC_W          = 8;
    localparam int THR_W           = 32;
    localparam logic [THR_W-1:0] THR_RESET = 32'd4295;
    localparam int QUEUE_DEPTH     = 16;
    localparam int CRED_W          = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_TDW         = ((DIST_W + 7) / 8) * 8;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    function automatic int f_nw(input int cw);
        return 6 * (cw + 1) + 8;
    endfunction

    function automatic int f_denw(input int cw);
        return 4 * cw + 8;
    endfunction

    function automatic int f_ew(input int cw);
        return f_nw(cw) + f_denw(cw) + 1;
    endfunction
endpackage
`default_nettype wire

@@ src/l2l_front.sv @@
// Front pipeline: differences, dot products, parallel test, numerator and denominator.
`default_nettype none
module l2l_front #(
    parameter int CW = l2l_pkg::COORD_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [l2l_pkg::NUM_FIELDS*CW-1:0]   i_data,
    input  logic [l2l_pkg::THR_W-1:0]           i_thr,
    input  logic                                i_pop,
    output logic                                o_push,
    output logic [l2l_pkg::f_ew(CW)-1:0]        o_entry
);
    import l2l_pkg::*;

    localparam int DW   = CW + 1;
    localparam int PW   = 2 * DW + 2;
    localparam int DDW  = 2 * PW;
    localparam int TW   = 3 * DW + 4;
    localparam int HW   = (TW + 1) / 2;
    localparam int HHW  = TW - HW;
    localparam int PPW  = 2 * PW + 1;
    localparam int NW   = f_nw(CW);
    localparam int DENW = f_denw(CW);
    localparam int NST  = 8;

    logic [CRED_W-1:0] r_cred, n_cred;
    logic [NST:1]      r_vld;
    logic              s_acc;

    logic signed [DW-1:0]   r_u[3], r_v[3], r_w[3];
    logic signed [2*DW-1:0] r_puu[3], r_puv[3], r_pvv[3], r_puw[3], r_pvw[3], r_pww[3];
    logic signed [2*DW-1:0] r_x1[3], r_x2[3];
    logic signed [DW-1:0]   r_w2[3], r_w3[3];
    logic signed [PW-1:0]   r_a3, r_b3, r_c3, r_d3, r_e3, r_g3, r_n3[3];
    logic signed [DDW-1:0]  r_ac4, r_b24;
    logic signed [TW-1:0]   r_tp4[3];
    logic signed [PW-1:0]   r_b4, r_c4, r_d4, r_e4, r_g4;
    logic signed [DDW-1:0]  r_dd5, r_b25, r_bd5, r_d25, r_cg5, r_e25;
    logic signed [TW-1:0]   r_t5;
    logic signed [PW-1:0]   r_b5, r_c5, r_e5, r_g5;
    logic                   r_par6, r_bgc6, r_cpos6;
    logic signed [DDW-1:0]  r_dd6, r_b26, r_num36;
    logic [2*HW-1:0]        r_tll6;
    logic signed [TW:0]     r_tlh6;
    logic signed [2*HHW-1:0] r_thh6;
    logic signed [PPW-1:0]  r_bgl6, r_bgh6, r_bel6, r_beh6, r_dcl6, r_dch6;
    logic signed [PW-1:0]   r_c6, r_g6;
    logic                   r_par7, r_bgc7, r_cpos7;
    logic signed [DDW-1:0]  r_dd7, r_b27, r_num37;
    logic signed [NW-1:0]   r_t27, r_bbg7, r_bde7, r_ddc7;
    logic signed [PW-1:0]   r_c7, r_g7;
    logic [f_ew(CW)-1:0]    r_entry;

    logic signed [NW-1:0]   s_npar, s_num;
    logic signed [DENW-1:0] s_den;
    logic signed [CW-1:0]   s_f[NUM_FIELDS];

    assign s_acc   = i_valid && o_ready;
    assign o_ready = (r_cred < CRED_W'(QUEUE_DEPTH));
    assign o_push  = r_vld[NST];
    assign o_entry = r_entry;

    always_comb begin
        for (int k = 0; k < NUM_FIELDS; k++) begin
            s_f[k] = $signed(i_data[k*CW +: CW]);
        end
        n_cred = r_cred + CRED_W'(s_acc) - CRED_W'(i_pop);
    end

    // in-flight plus queued requests
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cred <= '0;
            r_vld  <= '0;
        end else begin
            r_cred <= n_cred;
            r_vld  <= {r_vld[NST-1:1], s_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_u[i] <= DW'(s_f[3+i]) - DW'(s_f[i]);
            r_v[i] <= DW'(s_f[9+i]) - DW'(s_f[6+i]);
            r_w[i] <= DW'(s_f[i]) - DW'(s_f[6+i]);

            r_puu[i] <= (2*DW)'(r_u[i]) * (2*DW)'(r_u[i]);
            r_puv[i] <= (2*DW)'(r_u[i]) * (2*DW)'(r_v[i]);
            r_pvv[i] <= (2*DW)'(r_v[i]) * (2*DW)'(r_v[i]);
            r_puw[i] <= (2*DW)'(r_u[i]) * (2*DW)'(r_w[i]);
            r_pvw[i] <= (2*DW)'(r_v[i]) * (2*DW)'(r_w[i]);
            r_pww[i] <= (2*DW)'(r_w[i]) * (2*DW)'(r_w[i]);
            r_x1[i]  <= (2*DW)'(r_u[(i+1)%3]) * (2*DW)'(r_v[(i+2)%3]);
            r_x2[i]  <= (2*DW)'(r_u[(i+2)%3]) * (2*DW)'(r_v[(i+1)%3]);
            r_w2[i]  <= r_w[i];

            r_n3[i] <= PW'(r_x1[i]) - PW'(r_x2[i]);
            r_w3[i] <= r_w2[i];

            r_tp4[i] <= TW'(r_w3[i]) * TW'(r_n3[i]);
        end

        r_a3 <= PW'(r_puu[0]) + PW'(r_puu[1]) + PW'(r_puu[2]);
        r_b3 <= PW'(r_puv[0]) + PW'(r_puv[1]) + PW'(r_puv[2]);
        r_c3 <= PW'(r_pvv[0]) + PW'(r_pvv[1]) + PW'(r_pvv[2]);
        r_d3 <= PW'(r_puw[0]) + PW'(r_puw[1]) + PW'(r_puw[2]);
        r_e3 <= PW'(r_pvw[0]) + PW'(r_pvw[1]) + PW'(r_pvw[2]);
        r_g3 <= PW'(r_pww[0]) + PW'(r_pww[1]) + PW'(r_pww[2]);

        r_ac4 <= DDW'(r_a3) * DDW'(r_c3);
        r_b24 <= DDW'(r_b3) * DDW'(r_b3);
        r_b4  <= r_b3;
        r_c4  <= r_c3;
        r_d4  <= r_d3;
        r_e4  <= r_e3;
        r_g4  <= r_g3;

        r_dd5 <= r_ac4 - r_b24;
        r_t5  <= r_tp4[0] + r_tp4[1] + r_tp4[2];
        r_b25 <= r_b24;
        r_bd5 <= DDW'(r_b4) * DDW'(r_d4);
        r_d25 <= DDW'(r_d4) * DDW'(r_d4);
        r_cg5 <= DDW'(r_c4) * DDW'(r_g4);
        r_e25 <= DDW'(r_e4) * DDW'(r_e4);
        r_b5  <= r_b4;
        r_c5  <= r_c4;
        r_e5  <= r_e4;
        r_g5  <= r_g4;

        r_par6  <= ($unsigned(r_dd5) < DDW'(i_thr)) || (r_dd5 == '0);
        r_bgc6  <= (r_b5 > r_c5);
        r_cpos6 <= (r_c5 > PW'(0));
        r_dd6   <= r_dd5;
        r_b26   <= r_b25;
        r_num36 <= r_cg5 - r_e25;
        r_c6    <= r_c5;
        r_g6    <= r_g5;
        r_tll6  <= (2*HW)'(r_t5[HW-1:0]) * (2*HW)'(r_t5[HW-1:0]);
        r_tlh6  <= (TW+1)'($signed({1'b0, r_t5[HW-1:0]})) * (TW+1)'($signed(r_t5[TW-1:HW]));
        r_thh6  <= (2*HHW)'($signed(r_t5[TW-1:HW])) * (2*HHW)'($signed(r_t5[TW-1:HW]));
        r_bgl6  <= PPW'($signed({1'b0, r_b25[PW-1:0]})) * PPW'(r_g5);
        r_bgh6  <= PPW'($signed(r_b25[DDW-1:PW])) * PPW'(r_g5);
        r_bel6  <= PPW'($signed({1'b0, r_bd5[PW-1:0]})) * PPW'(r_e5);
        r_beh6  <= PPW'($signed(r_bd5[DDW-1:PW])) * PPW'(r_e5);
        r_dcl6  <= PPW'($signed({1'b0, r_d25[PW-1:0]})) * PPW'(r_c5);
        r_dch6  <= PPW'($signed(r_d25[DDW-1:PW])) * PPW'(r_c5);

        r_par7  <= r_par6;
        r_bgc7  <= r_bgc6;
        r_cpos7 <= r_cpos6;
        r_dd7   <= r_dd6;
        r_b27   <= r_b26;
        r_num37 <= r_num36;
        r_c7    <= r_c6;
        r_g7    <= r_g6;
        r_t27   <= (NW'(r_thh6) <<< (2*HW)) + (NW'(r_tlh6) <<< (HW+1)) + NW'(r_tll6);
        r_bbg7  <= (NW'(r_bgh6) <<< PW) + NW'(r_bgl6);
        r_bde7  <= (NW'(r_beh6) <<< PW) + NW'(r_bel6);
        r_ddc7  <= (NW'(r_dch6) <<< PW) + NW'(r_dcl6);

        r_entry <= {r_par7, s_den, s_num};
    end

    always_comb begin
        s_npar = r_bbg7 - (r_bde7 <<< 1) + r_ddc7;
        if (!r_par7) begin
            s_num = r_t27;
            s_den = DENW'(r_dd7);
        end else if (r_bgc7) begin
            s_num = s_npar;
            s_den = DENW'(r_b27);
        end else if (r_cpos7) begin
            s_num = NW'(r_num37);
            s_den = DENW'(r_c7);
        end else begin
            s_num = NW'(r_g7);
            s_den = DENW'(1);
        end
    end
endmodule
`default_nettype wire

@@ src/l2l_fifo.sv @@
// Request queue between front and back pipelines.
`default_nettype none
module l2l_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = l2l_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic [W-1:0]    i_data,
    input  logic            i_pop,
    output logic [W-1:0]    o_data,
    output l2l_pkg::t_qstat o_stat
);
    import l2l_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [W-1:0]  r_mem[DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_data       = r_mem[r_rp];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == (AW+1)'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + AW'(1);
            if (i_pop)  r_rp <= r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

@@ src/l2l_back.sv @@
// Back pipeline: integer quotient by restoring division, then digit-by-digit square root.
`default_nettype none
module l2l_back #(
    parameter int CW = l2l_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  l2l_pkg::t_qstat               i_stat,
    input  logic [l2l_pkg::f_ew(CW)-1:0]  i_entry,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [l2l_pkg::DIST_W-1:0]    o_dist,
    output logic                          o_par
);
    import l2l_pkg::*;

    localparam int NW   = f_nw(CW);
    localparam int DENW = f_denw(CW);
    localparam int RW   = DENW + 1;
    localparam int QW   = 2 * DIST_W;
    localparam int SH   = QW;
    localparam int CMPW = (NW > DENW + SH) ? NW : DENW + SH;

    logic              s_en;
    logic [NW-1:0]     s_num;
    logic [DENW-1:0]   s_den;

    logic [QW:0]       r_dv;
    logic [RW-1:0]     r_rem[QW+1];
    logic [QW-1:0]     r_qx[QW+1];
    logic [DENW-1:0]   r_den[QW+1];
    logic              r_dsat[QW+1];
    logic              r_dpar[QW+1];
    logic [RW-1:0]     c_rem[QW];
    logic [QW-1:0]     c_qx[QW];

    logic [DIST_W-1:0] r_sv;
    logic [QW-1:0]     r_sq[DIST_W];
    logic [DIST_W-1:0] r_sr[DIST_W];
    logic              r_spar[DIST_W];
    logic [QW-1:0]     c_qin[DIST_W];
    logic [DIST_W-1:0] c_rin[DIST_W];
    logic [DIST_W-1:0] c_rout[DIST_W];
    logic [DIST_W-1:0] c_cand;
    logic [RW-1:0]     c_shf;
    logic [RW:0]       c_diff;

    assign s_num   = i_entry[NW-1:0];
    assign s_den   = i_entry[NW +: DENW];
    assign s_en    = !r_sv[DIST_W-1] || i_ready;
    assign o_pop   = s_en && !i_stat.empty;
    assign o_valid = r_sv[DIST_W-1];
    assign o_dist  = r_sr[DIST_W-1];
    assign o_par   = r_spar[DIST_W-1];

    always_comb begin
        c_shf  = '0;
        c_diff = '0;
        for (int i = 0; i < QW; i++) begin
            c_shf  = {r_rem[i][RW-2:0], r_qx[i][QW-1]};
            c_diff = {1'b0, c_shf} - {2'b00, r_den[i]};
            c_rem[i] = c_diff[RW] ? c_shf : c_diff[RW-1:0];
            c_qx[i]  = {r_qx[i][QW-2:0], !c_diff[RW]};
        end
    end

    always_comb begin
        c_cand   = '0;
        c_qin[0] = r_dsat[QW] ? '1 : r_qx[QW];
        c_rin[0] = '0;
        for (int j = 1; j < DIST_W; j++) begin
            c_qin[j] = r_sq[j-1];
            c_rin[j] = r_sr[j-1];
        end
        for (int j = 0; j < DIST_W; j++) begin
            c_cand    = c_rin[j] | (DIST_W'(1) << (DIST_W - 1 - j));
            c_rout[j] = ((QW'(c_cand) * QW'(c_cand)) <= c_qin[j]) ? c_cand : c_rin[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
            r_sv <= '0;
        end else if (s_en) begin
            r_dv <= {r_dv[QW-1:0], o_pop};
            r_sv <= {r_sv[DIST_W-2:0], r_dv[QW]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_rem[0]  <= RW'(s_num >> SH);
            r_qx[0]   <= s_num[SH-1:0];
            r_den[0]  <= s_den;
            r_dsat[0] <= CMPW'(s_num) >= CMPW'({s_den, {SH{1'b0}}});
            r_dpar[0] <= i_entry[NW+DENW];
            for (int i = 0; i < QW; i++) begin
                r_rem[i+1]  <= c_rem[i];
                r_qx[i+1]   <= c_qx[i];
                r_den[i+1]  <= r_den[i];
                r_dsat[i+1] <= r_dsat[i];
                r_dpar[i+1] <= r_dpar[i];
            end
            for (int j = 0; j < DIST_W; j++) begin
                r_sq[j] <= c_qin[j];
                r_sr[j] <= c_rout[j];
            end
            r_spar[0] <= r_dpar[QW];
            for (int j = 1; j < DIST_W; j++) begin
                r_spar[j] <= r_spar[j-1];
            end
        end
    end
endmodule
`default_nettype wire

@@ src/line_to_line_distance_3d_top.sv @@
// Top level of the closest distance between two 3D lines.
//
//  channel   dir  handshake                      payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready line pair, 12 coordinates
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready distance (tdata), parallel flag (tuser)
//  cfg       in   i_cfg_valid/o_cfg_ready         parallel threshold
//
// One request per cycle sustained. Requests pass the front pipe, the queue, the division
// stages and the square root. Acceptance is limited by 16 credits covering the front
// pipe and the queue; an output stall freezes the back pipe while the front keeps filling
// the queue. Synchronous active-low reset clears control state and loads threshold 4295.
`default_nettype none
`include "line_to_line_distance_3d_top_macros.svh"
module line_to_line_distance_3d_top #(
    parameter int COORD_WIDTH = l2l_pkg::COORD_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // line1_start_x/y/z, line1_end_x/y/z, line2_start_x/y/z, line2_end_x/y/z
    input  logic [((l2l_pkg::NUM_FIELDS*COORD_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // closest_distance, zero fill
    output logic [l2l_pkg::OUT_TDW-1:0] o_m_axis_tdata,
    // lines_parallel
    output logic o_m_axis_tuser,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic [l2l_pkg::THR_W-1:0] i_cfg_data
);
    import l2l_pkg::*;

    localparam int EW = f_ew(COORD_WIDTH);

    logic [THR_W-1:0]  r_thr;
    logic              s_cfg_wr, s_push, s_pop;
    logic [EW-1:0]     s_entry_in, s_entry_out;
    t_qstat            s_qstat;
    logic [DIST_W-1:0] s_dist;

    assign o_cfg_ready    = 1'b1;
    assign s_cfg_wr       = i_cfg_valid && o_cfg_ready;
    assign o_m_axis_tdata = OUT_TDW'(s_dist);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (s_cfg_wr) begin
            r_thr <= i_cfg_data;
        end
    end

    l2l_front #(.CW(COORD_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata[NUM_FIELDS*COORD_WIDTH-1:0]),
        .i_thr   (r_thr),
        .i_pop   (s_pop),
        .o_push  (s_push),
        .o_entry (s_entry_in)
    );

    l2l_fifo #(.W(EW), .DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_data  (s_entry_in),
        .i_pop   (s_pop),
        .o_data  (s_entry_out),
        .o_stat  (s_qstat)
    );

    l2l_back #(.CW(COORD_WIDTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (s_qstat),
        .i_entry (s_entry_out),
        .o_pop   (s_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_dist  (s_dist),
        .o_par   (o_m_axis_tuser)
    );

    `L2L_ASSERT_IMP(a_push_room, i_clk, i_rst_n, s_push, !s_qstat.full)
    `L2L_ASSERT_IMP(a_pop_avail, i_clk, i_rst_n, s_pop, !s_qstat.empty)
    `L2L_ASSERT_IMP(a_stall_nopop, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, !s_pop)
    `L2L_ASSERT_NXT(a_cfg_load, i_clk, i_rst_n, s_cfg_wr, r_thr == $past(i_cfg_data))
endmodule
`default_nettype wire
